@@ rtl/core/bdq_pkg.sv @@
// Shared types for the bounded deque: command and status codes, datapath control
// and status groups, and controller states. No dependencies.
package bdq_pkg;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_SEARCH     = 3'd4,
      CMD_LENGTH     = 3'd5
   } bdq_cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_EMPTY     = 2'd1,
      STS_FULL      = 2'd2,
      STS_NOT_FOUND = 2'd3
   } bdq_status_type;

   // where the result value comes from
   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_DATA  = 2'd1,
      SRC_COUNT = 2'd2,
      SRC_PEND  = 2'd3
   } bdq_src_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_EXEC  = 2'd1,
      S_SCAN  = 2'd2,
      S_FLUSH = 2'd3
   } bdq_state_type;

   typedef struct packed {
      logic           load;
      logic           push;
      logic           pop;
      logic           scan_step;
      logic           pend_set;
      logic           out_load;
      bdq_status_type out_status;
      bdq_src_type    out_src;
      logic           out_last;
   } bdq_dp_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       empty;
      logic       full;
      logic       match;
      logic       scan_end;
      logic       pend_vld;
      logic       out_free;
   } bdq_dp_sts_type;

endpackage

@@ rtl/core/bdq_datapath.sv @@
// Deque datapath: slot memory, front index, entry count, search scan and
// result register. Depends on bdq_pkg.
module bdq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [2:0]              req_cmd,
   input  logic signed [31:0]      req_value,
   input  bdq_pkg::bdq_dp_cmd_type dp_cmd,
   output bdq_pkg::bdq_dp_sts_type dp_sts,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_result_value,
   output logic                    rsp_last
);
   import bdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [31:0]      mem [DEPTH];
   logic [31:0]      rd_data_ff;
   logic [2:0]       cmd_ff;
   logic [31:0]      key_ff;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] pend_ff, pend_in;
   logic             pend_vld_ff, pend_vld_in;
   logic             out_vld_ff, out_vld_in;
   logic [1:0]       out_status_ff;
   logic [31:0]      out_value_ff, out_value_in;
   logic             out_last_ff;

   logic [SUM_W-1:0] tail_sum;
   logic [IDX_W-1:0] tail_idx, back_idx, front_inc, front_dec, pos_inc;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             is_front;

   // slot after the last entry, and the last entry itself
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign tail_idx  = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);
   assign back_idx  = (tail_idx == '0) ? LAST_IDX : tail_idx - 1'b1;
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign pos_inc   = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;

   // push and pop go front or back by the low command bit
   assign is_front = (cmd_ff == CMD_PUSH_FRONT) || (cmd_ff == CMD_POP_FRONT);
   assign wr_en    = dp_cmd.push;
   assign wr_addr  = is_front ? front_dec : tail_idx;

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (dp_cmd.push) begin
         count_in = count_ff + 1'b1;
         if (is_front) begin
            front_in = front_dec;
         end
      end else if (dp_cmd.pop) begin
         count_in = count_ff - 1'b1;
         if (is_front) begin
            front_in = front_inc;
         end
      end
   end

   // memory read address is the next slot position
   always_comb begin
      pos_in      = pos_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      if (dp_cmd.load) begin
         pos_in      = (req_cmd == CMD_POP_BACK) ? back_idx : front_ff;
         scan_in     = '0;
         pend_vld_in = 1'b0;
      end else if (dp_cmd.scan_step) begin
         pos_in  = pos_inc;
         scan_in = scan_ff + 1'b1;
      end
      if (dp_cmd.pend_set) begin
         pend_in     = scan_ff;
         pend_vld_in = 1'b1;
      end
   end

   always_comb begin
      unique case (dp_cmd.out_src)
         SRC_ZERO:  out_value_in = '0;
         SRC_DATA:  out_value_in = rd_data_ff;
         SRC_COUNT: out_value_in = 32'(count_ff);
         SRC_PEND:  out_value_in = 32'(pend_ff);
         default:   out_value_in = '0;
      endcase
   end

   always_comb begin
      if (dp_cmd.out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= key_ff;
      end
      rd_data_ff <= mem[pos_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         front_ff    <= front_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff <= req_cmd;
         key_ff <= req_value;
      end
      pos_ff  <= pos_in;
      scan_ff <= scan_in;
      pend_ff <= pend_in;
      if (dp_cmd.out_load) begin
         out_status_ff <= dp_cmd.out_status;
         out_value_ff  <= out_value_in;
         out_last_ff   <= dp_cmd.out_last;
      end
   end

   assign dp_sts.cmd      = cmd_ff;
   assign dp_sts.empty    = (count_ff == '0);
   assign dp_sts.full     = (count_ff == FULL_CNT);
   assign dp_sts.match    = (rd_data_ff == key_ff);
   assign dp_sts.scan_end = (CNT_W'(scan_ff) == count_ff - 1'b1);
   assign dp_sts.pend_vld = pend_vld_ff;
   assign dp_sts.out_free = !out_vld_ff || rsp_ready;

   assign rsp_valid        = out_vld_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_last         = out_last_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("entry count beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.pend_set |=> pend_vld_ff && (pend_ff == $past(scan_ff)))
      else $error("pending match position lost");

endmodule

@@ rtl/core/bdq_ctrl.sv @@
// Deque controller: sequences one request at a time through execute and, for a search
// of a non-empty deque, scan and flush. Depends on bdq_pkg.
module bdq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bdq_pkg::bdq_dp_sts_type dp_sts,
   output bdq_pkg::bdq_dp_cmd_type dp_cmd
);
   import bdq_pkg::*;

   bdq_state_type state_ff, state_in;
   logic          stall;

   assign req_ready = (state_ff == S_IDLE);
   // a second match cannot be taken while the previous one is still unsent
   assign stall = dp_sts.match && dp_sts.pend_vld && !dp_sts.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if ((dp_sts.cmd == CMD_SEARCH) && !dp_sts.empty) begin
               state_in = S_SCAN;
            end else if (dp_sts.out_free || (dp_sts.cmd > CMD_LENGTH)) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (!stall && dp_sts.scan_end) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (dp_sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd            = '0;
      dp_cmd.out_status = STS_OK;
      dp_cmd.out_src    = SRC_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            dp_cmd.load = req_valid;
         end
         S_EXEC: begin
            dp_cmd.out_last = 1'b1;
            unique case (dp_sts.cmd)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  dp_cmd.out_load = dp_sts.out_free;
                  if (dp_sts.full) begin
                     dp_cmd.out_status = STS_FULL;
                  end else begin
                     dp_cmd.push = dp_sts.out_free;
                  end
               end
               CMD_POP_FRONT, CMD_POP_BACK: begin
                  dp_cmd.out_load = dp_sts.out_free;
                  if (dp_sts.empty) begin
                     dp_cmd.out_status = STS_EMPTY;
                  end else begin
                     dp_cmd.pop     = dp_sts.out_free;
                     dp_cmd.out_src = SRC_DATA;
                  end
               end
               CMD_SEARCH: begin
                  if (dp_sts.empty) begin
                     dp_cmd.out_load   = dp_sts.out_free;
                     dp_cmd.out_status = STS_EMPTY;
                  end
               end
               CMD_LENGTH: begin
                  dp_cmd.out_load = dp_sts.out_free;
                  if (dp_sts.empty) begin
                     dp_cmd.out_status = STS_EMPTY;
                  end else begin
                     dp_cmd.out_src = SRC_COUNT;
                  end
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            if (!stall) begin
               dp_cmd.scan_step = !dp_sts.scan_end;
               dp_cmd.pend_set  = dp_sts.match;
               // a new match releases the one held before it
               dp_cmd.out_load  = dp_sts.match && dp_sts.pend_vld;
               dp_cmd.out_src   = SRC_PEND;
            end
         end
         S_FLUSH: begin
            dp_cmd.out_load = dp_sts.out_free;
            dp_cmd.out_last = 1'b1;
            if (dp_sts.pend_vld) begin
               dp_cmd.out_src = SRC_PEND;
            end else begin
               dp_cmd.out_status = STS_NOT_FOUND;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) dp_cmd.out_load |-> dp_sts.out_free)
      else $error("result register overwritten before delivery");
   assert property (@(posedge clock) disable iff (reset) dp_cmd.push |-> !dp_sts.full)
      else $error("push into a full ring");
   assert property (@(posedge clock) disable iff (reset) dp_cmd.pop |-> !dp_sts.empty)
      else $error("pop from an empty ring");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !dp_sts.empty)
      else $error("scan running over an empty ring");

endmodule

@@ rtl/core/bounded_deque_with_search.sv @@
// Bounded deque of 32-bit values with search by value. The result of push, pop or
// length is registered once the request has executed; no new request is taken until
// that result is loaded. A search scans one stored entry per cycle through the single
// read port of the slot memory, unless a result stall holds it, and gives its last
// result after the scan; only then is the next request taken.
// Synchronous reset empties the deque; slot contents are kept undefined.
module bounded_deque_with_search #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_last
);
   import bdq_pkg::*;

   bdq_dp_cmd_type dp_cmd;
   bdq_dp_sts_type dp_sts;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_sts    (dp_sts),
      .dp_cmd    (dp_cmd)
   );

   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .dp_cmd           (dp_cmd),
      .dp_sts           (dp_sts),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last)
   );

endmodule
